// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// ===== rtl/core/dxt_pkg.sv =====
package dxt_pkg;

    localparam logic [1:0] MODE_DXT1 = 2'd0;
    localparam logic [1:0] MODE_DXT3 = 2'd1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Block after stage 1: expanded color endpoints, mode flags, alpha half and color indices.
    typedef struct packed {
        rgb_t        e0;
        rgb_t        e1;
        logic        four_color;
        logic        dxt3;
        logic        dxt5;
        logic [63:0] alpha_half;
        logic [31:0] cbits;
    } blk_s1_t;

    // Block after stage 2: full palettes.
    typedef struct packed {
        logic [3:0][23:0] pal;
        logic [3:0]       pal_opaque;
        logic [7:0][7:0]  apal;
        logic             dxt3;
        logic             dxt5;
        logic [63:0]      alpha_half;
        logic [31:0]      cbits;
    } blk_s2_t;

    // v*255/31 truncated = 8v + 7v/31
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0]  y;
        logic [15:0] p;
        y = 8'(v) * 8'd7;
        p = 16'(y) * 16'd265;
        return {v, 3'b000} + 8'(p[15:13]);
    endfunction

    // v*255/63 truncated = 4v + v/21
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] q;
        q = (v >= 6'd63) ? 2'd3 : (v >= 6'd42) ? 2'd2 : (v >= 6'd21) ? 2'd1 : 2'd0;
        return {v, 2'b00} + 8'(q);
    endfunction

    // x/3 for x < 766 via reciprocal multiply.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd683;
        return p[18:11];
    endfunction

    // x/7 for x < 1786.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd2341;
        return p[21:14];
    endfunction

    // x/5 for x < 1276.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd3277;
        return p[21:14];
    endfunction

endpackage

// ===== rtl/core/dxt_block_decoder.sv =====
// A block beat passes the endpoint, palette and row registers before row 0 goes out; rows
// follow one per cycle unless stalled. The single row emitter takes the next block after row 3.
// Three registered stages: endpoint expand, palette build, row select.
// rst_n asynchronously clears valids, row counter and format_mode (DXT1).
`include "assert_macros.svh"
module dxt_block_decoder
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data,        // format_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,    // alpha_half[63:0], color_half[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,    // row_index[1:0], texel0..3 [33:2]..[129:98], pad
    output logic         m_axis_tlast     // last_row
);
    import dxt_pkg::*;

    logic       [1:0] mode_reg;
    logic             v1;
    logic             r1;
    logic             v2;
    logic             r2;
    blk_s1_t          b1;
    blk_s2_t          b2;
    logic       [1:0] row;
    logic [3:0][31:0] texels;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DXT1;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    dxt_endpoints u_ep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .mode       (mode_reg),
        .alpha_half (s_axis_tdata[63:0]),
        .color_half (s_axis_tdata[127:64]),
        .out_valid  (v1),
        .out_ready  (r1),
        .out_blk    (b1)
    );

    dxt_palette u_pal
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_blk    (b1),
        .out_valid (v2),
        .out_ready (r2),
        .out_blk   (b2)
    );

    dxt_row_emit u_row
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_blk    (b2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .row       (row),
        .texels    (texels),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, texels[3], texels[2], texels[1], texels[0], row};

    `ASSERT_IMPLY(a_last_row, clk, rst_n, m_axis_tvalid,
        m_axis_tlast == (m_axis_tdata[1:0] == 2'd3), "tlast does not match row 3")
    `ASSERT_NEXT(a_row_step, clk, rst_n, m_axis_tvalid && m_axis_tready,
        !m_axis_tvalid || m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1,
        "row sequence broken")
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")
endmodule

// ===== rtl/core/dxt_endpoints.sv =====
module dxt_endpoints
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  logic [63:0]          alpha_half,
    input  logic [63:0]          color_half,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dxt_pkg::blk_s1_t     out_blk
);
    import dxt_pkg::*;

    logic     valid_reg;
    blk_s1_t  blk_reg;
    blk_s1_t  blk_next;
    logic     dxt5;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;
    assign dxt5      = mode[1];

    always_comb
    begin
        blk_next.e0.r       = expand5(color_half[15:11]);
        blk_next.e0.g       = expand6(color_half[10:5]);
        blk_next.e0.b       = expand5(color_half[4:0]);
        blk_next.e1.r       = expand5(color_half[31:27]);
        blk_next.e1.g       = expand6(color_half[26:21]);
        blk_next.e1.b       = expand5(color_half[20:16]);
        blk_next.dxt5       = dxt5;
        blk_next.dxt3       = !dxt5 && (mode == MODE_DXT3);
        blk_next.four_color = (mode != MODE_DXT1) || (color_half[15:0] > color_half[31:16]);
        blk_next.alpha_half = alpha_half;
        blk_next.cbits      = color_half[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            blk_reg <= blk_next;
        end
    end
endmodule

// ===== rtl/core/dxt_palette.sv =====
module dxt_palette
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dxt_pkg::blk_s1_t     in_blk,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dxt_pkg::blk_s2_t     out_blk
);
    import dxt_pkg::*;

    logic     valid_reg;
    blk_s2_t  blk_reg;
    blk_s2_t  blk_next;
    logic [7:0] a0;
    logic [7:0] a1;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;
    assign a0        = in_blk.alpha_half[7:0];
    assign a1        = in_blk.alpha_half[15:8];

    always_comb
    begin
        blk_next.pal[0]     = in_blk.e0;
        blk_next.pal[1]     = in_blk.e1;
        blk_next.pal_opaque = 4'b1111;
        if (in_blk.four_color)
        begin
            blk_next.pal[2] = {div3({1'b0, in_blk.e0.r, 1'b0} + 10'(in_blk.e1.r)),
                               div3({1'b0, in_blk.e0.g, 1'b0} + 10'(in_blk.e1.g)),
                               div3({1'b0, in_blk.e0.b, 1'b0} + 10'(in_blk.e1.b))};
            blk_next.pal[3] = {div3(10'(in_blk.e0.r) + {1'b0, in_blk.e1.r, 1'b0}),
                               div3(10'(in_blk.e0.g) + {1'b0, in_blk.e1.g, 1'b0}),
                               div3(10'(in_blk.e0.b) + {1'b0, in_blk.e1.b, 1'b0})};
        end
        else
        begin
            blk_next.pal[2] = {8'((9'(in_blk.e0.r) + 9'(in_blk.e1.r)) >> 1),
                               8'((9'(in_blk.e0.g) + 9'(in_blk.e1.g)) >> 1),
                               8'((9'(in_blk.e0.b) + 9'(in_blk.e1.b)) >> 1)};
            blk_next.pal[3]        = 24'd0;
            blk_next.pal_opaque[3] = 1'b0;
        end
        blk_next.apal[0] = a0;
        blk_next.apal[1] = a1;
        if (a0 > a1)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                blk_next.apal[k + 1] = div7(11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k));
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                blk_next.apal[k + 1] = div5(11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k));
            end
            blk_next.apal[6] = 8'd0;
            blk_next.apal[7] = 8'd255;
        end
        blk_next.dxt3       = in_blk.dxt3;
        blk_next.dxt5       = in_blk.dxt5;
        blk_next.alpha_half = in_blk.alpha_half;
        blk_next.cbits      = in_blk.cbits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            blk_reg <= blk_next;
        end
    end
endmodule

// ===== rtl/core/dxt_row_emit.sv =====
module dxt_row_emit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dxt_pkg::blk_s2_t     in_blk,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           row,
    output logic [3:0][31:0]     texels,
    output logic                 last
);
    import dxt_pkg::*;

    logic [1:0]       row_reg;
    logic             valid_reg;
    logic [1:0]       orow_reg;
    logic [3:0][31:0] tex_reg;
    logic [3:0][31:0] tex_next;
    logic             load;
    logic             fire;

    // one row per beat; block is released after row 3
    assign load      = !valid_reg || out_ready;
    assign fire      = load && in_valid;
    assign in_ready  = load && (row_reg == 2'd3);
    assign out_valid = valid_reg;
    assign row       = orow_reg;
    assign texels    = tex_reg;
    assign last      = (orow_reg == 2'd3);

    always_comb
    begin
        for (int x = 0; x < 4; x++)
        begin
            logic [1:0] ci;
            logic [2:0] ai;
            logic [3:0] a4;
            ci = in_blk.cbits[8 * row_reg + 2 * x +: 2];
            ai = in_blk.alpha_half[16 + 12 * row_reg + 3 * x +: 3];
            a4 = in_blk.alpha_half[16 * row_reg + 4 * x +: 4];
            tex_next[x][23:0]  = {in_blk.pal[ci][7:0], in_blk.pal[ci][15:8],
                                  in_blk.pal[ci][23:16]};
            tex_next[x][31:24] = in_blk.pal_opaque[ci] ? 8'd255 : 8'd0;
            if (in_blk.dxt3)
            begin
                tex_next[x][31:24] = {a4, a4};
            end
            else if (in_blk.dxt5)
            begin
                tex_next[x][31:24] = in_blk.apal[ai];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                row_reg <= row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            orow_reg <= row_reg;
            tex_reg  <= tex_next;
        end
    end
endmodule

// ===== verif/dxt_block_decoder_test.sv =====
`timescale 1ns / 100ps
module dxt_block_decoder_test;
    import dxt_pkg::*;

    localparam logic [1:0] MODE_DXT5 = 2'd2;
    localparam logic [1:0] MODE_ALT5 = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] texel [4];
        logic        last;
    } row_t;

    typedef struct {
        logic [63:0] alpha;
        logic [63:0] color;
    } block_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;

    block_t pending_blocks[$];
    row_t   expected_rows[$];
    logic [1:0] mode;
    int     errors = 0;
    int     cycles = 0;
    int     send_wait;
    int     recv_wait;
    int     hold_off;
    bit     hold_request;
    bit     feeding_done;

    dxt_block_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] rgba(int r, int g, int b, int a);
        return {a[7:0], b[7:0], g[7:0], r[7:0]};
    endfunction

    // Expected rows for one block under the current format
    function automatic void decode_block(block_t blk, logic [1:0] fmt);
        int c0, c1, r0, g0, b0, r1, g1, b1, k, y, x, pos, a4, ai;
        int pal [4];
        int av [8];
        bit dxt5, dxt3;
        row_t res;
        dxt5 = fmt[1];
        dxt3 = !dxt5 && fmt == MODE_DXT3;
        c0 = blk.color[15:0];
        c1 = blk.color[31:16];
        r0 = (c0 >> 11) * 255 / 31; g0 = ((c0 >> 5) & 63) * 255 / 63; b0 = (c0 & 31) * 255 / 31;
        r1 = (c1 >> 11) * 255 / 31; g1 = ((c1 >> 5) & 63) * 255 / 63; b1 = (c1 & 31) * 255 / 31;
        pal[0] = rgba(r0, g0, b0, 255);
        pal[1] = rgba(r1, g1, b1, 255);
        if (dxt3 || dxt5 || c0 > c1)
        begin
            pal[2] = rgba((2*r0+r1)/3, (2*g0+g1)/3, (2*b0+b1)/3, 255);
            pal[3] = rgba((r0+2*r1)/3, (g0+2*g1)/3, (b0+2*b1)/3, 255);
        end
        else
        begin
            pal[2] = rgba((r0+r1)/2, (g0+g1)/2, (b0+b1)/2, 255);
            pal[3] = 0;
        end
        av[0] = blk.alpha[7:0];
        av[1] = blk.alpha[15:8];
        if (av[0] > av[1])
            for (k = 1; k <= 6; k++) av[k+1] = ((7-k)*av[0] + k*av[1]) / 7;
        else
        begin
            for (k = 1; k <= 4; k++) av[k+1] = ((5-k)*av[0] + k*av[1]) / 5;
            av[6] = 0;
            av[7] = 255;
        end
        for (y = 0; y < 4; y++)
        begin
            res.row = y[1:0];
            res.last = (y == 3);
            for (x = 0; x < 4; x++)
            begin
                pos = y*4 + x;
                res.texel[x] = pal[blk.color[32 + 2*pos +: 2]];
                if (dxt3)
                begin
                    a4 = blk.alpha[16*y + 4*x +: 4];
                    res.texel[x][31:24] = 8'(a4 * 17);
                end
                else if (dxt5)
                begin
                    ai = blk.alpha[16 + 3*pos +: 3];
                    res.texel[x][31:24] = av[ai][7:0];
                end
            end
            expected_rows.push_back(res);
        end
    endfunction

    task automatic report(string what);
        $display("mismatch: %s at cycle %0d", what, cycles);
        errors++;
    endtask

    // Driver: blocks are decoded into expectations when the beat is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_block(pending_blocks.pop_front(), mode);
                send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            end
            if ((s_axis_tvalid && !s_axis_tready))
                ;
            else if (send_wait > 0 && !(s_axis_tvalid && s_axis_tready))
            begin
                s_axis_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_blocks.size() > 0
                     && !(s_axis_tvalid && s_axis_tready && $urandom_range(0, 1)))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_blocks[0].color, pending_blocks[0].alpha};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        row_t got, want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
            hold_off <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.row = m_axis_tdata[1:0];
                for (int x = 0; x < 4; x++) got.texel[x] = m_axis_tdata[2 + 32*x +: 32];
                got.last = m_axis_tlast;
                if (expected_rows.size() == 0)
                    report("row beat with nothing expected");
                else
                begin
                    want = expected_rows.pop_front();
                    if (got.row !== want.row)
                        report($sformatf("row_index %0d, want %0d", got.row, want.row));
                    for (int x = 0; x < 4; x++)
                        if (got.texel[x] !== want.texel[x])
                            report($sformatf("row %0d texel%0d %h, want %h",
                                             want.row, x, got.texel[x], want.texel[x]));
                    if (got.last !== want.last)
                        report($sformatf("row %0d last_row %b", want.row, got.last));
                end
            end
            if (hold_request && hold_off == 0)
            begin
                hold_off <= 300;
                m_axis_tready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_axis_tready <= hold_off == 1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready && $urandom_range(0, 2) == 0)
                begin
                    m_axis_tready <= 1'b0;
                    recv_wait <= $urandom_range(0, 14);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic set_mode(logic [1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode = value;
    endtask

    task automatic drain();
        while (pending_blocks.size() > 0 || expected_rows.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_block(logic [63:0] a, logic [63:0] c);
        block_t b;
        b.alpha = a;
        b.color = c;
        pending_blocks.push_back(b);
    endtask

    task automatic random_blocks(int count);
        logic [63:0] a, c;
        for (int i = 0; i < count; i++)
        begin
            a = rand64();
            c = rand64();
            case ($urandom_range(0, 5))
                0: c[31:0] = {c[15:0], c[15:0]};
                1: a[15:0] = {a[7:0], a[7:0]};
                2: c[15:0] = 16'hffff;
                3: a = '1;
                default: ;
            endcase
            add_block(a, c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = MODE_DXT1;
        mode = MODE_DXT1;
        hold_request = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: endpoint order, extremes, equal endpoints
        add_block('0, '0);
        add_block('1, '1);
        add_block(64'h0, {32'he4e4e4e4, 16'h0000, 16'hffff});
        add_block(64'h0, {32'he4e4e4e4, 16'hffff, 16'h0000});
        add_block(64'h0, {32'h1b1b1b1b, 16'h1234, 16'h1234});
        add_block(64'h0, {32'hffffffff, 16'hf800, 16'h07e0});
        drain();
        set_mode(MODE_DXT3);
        add_block(64'hfedcba9876543210, {32'he4e4e4e4, 16'hffff, 16'h0000});
        add_block('1, {32'h1b1b1b1b, 16'h001f, 16'h001f});
        add_block('0, '1);
        drain();
        set_mode(MODE_DXT5);
        add_block({48'hfac688fac688, 8'h00, 8'hff}, {32'he4e4e4e4, 16'h07e0, 16'hf800});
        add_block({48'hfac688fac688, 8'hff, 8'h00}, 64'h0);
        add_block({48'hfac688fac688, 8'h40, 8'h40}, '1);
        add_block({48'hffffffffffff, 8'h10, 8'h20}, 64'h0);
        drain();
        set_mode(MODE_ALT5);
        add_block({48'hfac688fac688, 8'h01, 8'hc0}, rand64());
        add_block({48'hfac688fac688, 8'hc0, 8'h01}, rand64());
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            set_mode(phase == 3 ? MODE_ALT5 : phase[1:0]);
            random_blocks(40);
            if (phase == 1)
            begin
                while (pending_blocks.size() > 30) @(posedge clk);
                hold_request = 1;
                repeat (2) @(posedge clk);
                hold_request = 0;
            end
            drain();
        end
        set_mode(MODE_DXT1);
        random_blocks(40);
        drain();
        set_mode(MODE_DXT5);
        random_blocks(40);
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
